// ----- hdl/fla_pkg.sv -----
`default_nettype none

package fla_pkg;

  // Table size used when the top level is not overridden
  localparam int unsigned SlotsDefault = 1024;

  // Field widths fixed by the channel layout
  localparam int unsigned FuncW    = 2;
  localparam int unsigned SlotIdxW = 10;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned LiveW    = 11;

  // Request codes
  localparam logic [FuncW-1:0] FuncAlloc = 2'd0;
  localparam logic [FuncW-1:0] FuncFree  = 2'd1;
  localparam logic [FuncW-1:0] FuncFind  = 2'd2;

  // Result status codes
  localparam logic [StatusW-1:0] StOk   = 2'd0;
  localparam logic [StatusW-1:0] StNone = 2'd1;
  localparam logic [StatusW-1:0] StBad  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // take the request word, issue the first memory reads
    logic commit;     // finish an allocate, free or bad request
    logic scan_step;  // move the find scan on by one slot
    logic scan_hit;   // finish a find with the current slot
    logic scan_miss;  // finish a find with nothing found
  } fla_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_find;    // held request is a find
    logic scan_used;  // slot under the scan is in use
    logic scan_last;  // slot under the scan is the last one below the bump pointer
    logic out_free;   // result register can take a word this cycle
  } fla_sts_t;

endpackage

`default_nettype wire

// ----- hdl/fla_req_if.sv -----
`default_nettype none

interface fla_req_if import fla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FuncW-1:0]    func;
  logic [SlotIdxW-1:0] slot_index;

  modport source (output valid, func, slot_index, input ready);
  modport sink   (input valid, func, slot_index, output ready);
endinterface

`default_nettype wire

// ----- hdl/fla_rsp_if.sv -----
`default_nettype none

interface fla_rsp_if import fla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SlotIdxW-1:0] result_index;
  logic [StatusW-1:0]  status;
  logic [LiveW-1:0]    live_count;

  modport source (output valid, result_index, status, live_count, input ready);
  modport sink   (input valid, result_index, status, live_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/fla_ctrl.sv -----
`default_nettype none

module fla_ctrl import fla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  fla_sts_t sts_i,
  output fla_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StateIdle = 2'b01,
    StateBusy = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Sequence one request: accept, then finish or scan
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      StateIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StateBusy;
        end
      end
      StateBusy: begin
        priority if (!sts_i.is_find) begin
          if (sts_i.out_free) begin
            cmd_o.commit = 1'b1;
            state_d      = StateIdle;
          end
        end else if (sts_i.scan_used) begin
          if (sts_i.out_free) begin
            cmd_o.scan_hit = 1'b1;
            state_d        = StateIdle;
          end
        end else if (sts_i.scan_last) begin
          if (sts_i.out_free) begin
            cmd_o.scan_miss = 1'b1;
            state_d         = StateIdle;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: state_d = StateIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fla_dp.sv -----
`default_nettype none

module fla_dp import fla_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [FuncW-1:0]    req_func_i,
  input  logic [SlotIdxW-1:0] req_slot_index_i,
  input  logic                rsp_ready_i,
  output logic                rsp_valid_o,
  output logic [SlotIdxW-1:0] rsp_result_index_o,
  output logic [StatusW-1:0]  rsp_status_o,
  output logic [LiveW-1:0]    rsp_live_count_o,
  input  fla_cmd_t            cmd_i,
  output fla_sts_t            sts_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // Held request word
  logic [FuncW-1:0]    func_q;
  logic [SlotIdxW-1:0] idx_q;

  // Allocator state
  logic [IW-1:0] head_q, head_d;
  logic          empty_q, empty_d;
  logic [CW-1:0] bump_q, bump_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    used01_q, used01_d;
  logic [IW-1:0] scan_q;

  // Link memory: end-of-list flag over the next free slot
  logic [IW:0]   link_mem [SLOTS];
  logic [IW:0]   link_rd_q;
  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [IW:0]   link_wdata;

  // Used-mark memory; slots 0 and 1 live in flops, and a slot at or above
  // the bump pointer is treated as free by the free check
  logic          used_mem [SLOTS];
  logic          used_rd_q;
  logic [IW-1:0] used_raddr_q;
  logic          used_re;
  logic [IW-1:0] used_raddr;
  logic          used_we;
  logic [IW-1:0] used_waddr;
  logic          used_wdata;
  logic          used_bit;

  logic          mark_we;
  logic [IW-1:0] mark_addr;
  logic          mark_val;

  // Result register
  logic                out_valid_q;
  logic [SlotIdxW-1:0] out_idx_q;
  logic [StatusW-1:0]  out_st_q;
  logic [LiveW-1:0]    out_live_q;
  logic                out_free;
  logic                load_out;
  logic [IW-1:0]       res_slot;
  logic [StatusW-1:0]  res_st;
  logic                free_ok;

  // Hold the request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= req_func_i;
      idx_q  <= req_slot_index_i;
    end
  end

  // Pick the used-mark read address
  always_comb begin
    used_re    = cmd_i.load | cmd_i.scan_step;
    used_raddr = scan_q + IW'(1);
    if (cmd_i.load) begin
      used_raddr = (req_func_i == FuncFind) ? '0 : IW'(req_slot_index_i);
    end
  end

  // Memories with registered read data
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd_i.load) begin
      link_rd_q <= link_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
    if (used_re) begin
      used_rd_q    <= used_mem[used_raddr];
      used_raddr_q <= used_raddr;
    end
  end

  // Merge the flopped low slots with the memory read
  always_comb begin
    if (used_raddr_q < IW'(2)) begin
      used_bit = used01_q[used_raddr_q[0]];
    end else begin
      used_bit = used_rd_q;
    end
  end

  assign free_ok = (32'(idx_q) < SLOTS) && (32'(idx_q) < 32'(bump_q)) && used_bit;

  // Work out the request and the next allocator state
  always_comb begin
    head_d     = head_q;
    empty_d    = empty_q;
    bump_d     = bump_q;
    cnt_d      = cnt_q;
    link_we    = 1'b0;
    link_waddr = IW'(idx_q);
    link_wdata = {empty_q, (empty_q ? {IW{1'b0}} : head_q)};
    mark_we    = 1'b0;
    mark_addr  = head_q;
    mark_val   = 1'b1;
    res_slot   = '0;
    res_st     = StOk;
    if (cmd_i.commit) begin
      unique case (func_q)
        FuncAlloc: begin
          if (!empty_q) begin
            // Pop the head of the free list
            res_slot  = head_q;
            mark_we   = 1'b1;
            empty_d   = link_rd_q[IW];
            head_d    = link_rd_q[IW] ? '0 : link_rd_q[IW-1:0];
            cnt_d     = cnt_q + CW'(1);
          end else if (32'(bump_q) < SLOTS) begin
            // Take a fresh slot from the bump pointer
            res_slot  = bump_q[IW-1:0];
            mark_we   = 1'b1;
            mark_addr = bump_q[IW-1:0];
            bump_d    = bump_q + CW'(1);
            cnt_d     = cnt_q + CW'(1);
          end else begin
            res_st = StNone;
          end
        end
        FuncFree: begin
          if (free_ok) begin
            // Push the slot onto the free list
            link_we   = 1'b1;
            mark_we   = 1'b1;
            mark_addr = IW'(idx_q);
            mark_val  = 1'b0;
            head_d    = IW'(idx_q);
            empty_d   = 1'b0;
            cnt_d     = (cnt_q != '0) ? cnt_q - CW'(1) : cnt_q;
          end else begin
            res_st = StBad;
          end
        end
        // Find never commits here; the unused code is a bad request
        default: res_st = StBad;
      endcase
    end else if (cmd_i.scan_hit) begin
      res_slot = scan_q;
    end else if (cmd_i.scan_miss) begin
      res_st = StNone;
    end
  end

  // Route a used-mark write to the low flops or the memory
  always_comb begin
    used01_d   = used01_q;
    used_we    = 1'b0;
    used_waddr = mark_addr;
    used_wdata = mark_val;
    if (mark_we) begin
      if (mark_addr < IW'(2)) begin
        used01_d[mark_addr[0]] = mark_val;
      end else begin
        used_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      empty_q  <= 1'b1;
      bump_q   <= CW'(2);
      cnt_q    <= CW'(2);
      used01_q <= 2'b11;
      scan_q   <= '0;
    end else begin
      head_q   <= head_d;
      empty_q  <= empty_d;
      bump_q   <= bump_d;
      cnt_q    <= cnt_d;
      used01_q <= used01_d;
      if (cmd_i.load) begin
        scan_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + IW'(1);
      end
    end
  end

  // Result register: load a word when free, drop it when taken
  assign out_free = !out_valid_q || rsp_ready_i;
  assign load_out = cmd_i.commit | cmd_i.scan_hit | cmd_i.scan_miss;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_idx_q  <= SlotIdxW'(res_slot);
      out_st_q   <= res_st;
      out_live_q <= LiveW'(cnt_d);
    end
  end

  assign rsp_valid_o        = out_valid_q;
  assign rsp_result_index_o = out_idx_q;
  assign rsp_status_o       = out_st_q;
  assign rsp_live_count_o   = out_live_q;

  assign sts_o.is_find   = (func_q == FuncFind);
  assign sts_o.scan_used = used_bit;
  assign sts_o.scan_last = (32'(scan_q) + 1 >= 32'(bump_q));
  assign sts_o.out_free  = out_free;

  // Checks
  a_cnt_le_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bump_q) else $error("live count above bump pointer");

  a_bump_le_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bump_q) <= SLOTS) else $error("bump pointer beyond table");

  a_head_below_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> (32'(head_q) < 32'(bump_q))) else $error("free list head never allocated");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || rsp_ready_i)) else $error("result word overwritten");

endmodule

`default_nettype wire

// ----- hdl/free_list_slot_allocator.sv -----
// Slot allocator for a table of SLOTS entries.
// Requests arrive on req_i (func, slot_index) and each gives exactly one
// word on rsp_o (result_index, status, live_count), in request order.
// An allocate pops the head of a last-in-first-out free list, or takes the
// next never-used slot from a bump pointer; a free pushes the slot back;
// a find returns the lowest used slot below the bump pointer.
// An allocate, free or bad request is accepted and reads the link and
// used-mark memories, then updates them and loads the result.
// A find is accepted and then scans up from slot 0, one used-mark memory
// read per cycle, through at most the slots below the bump pointer.
// req_i.ready is high whenever no request is in progress.
// After reset slots 0 and 1 are in use, the bump pointer is 2 and the
// free list is empty; requests can be taken as soon as reset is released.
// The result sits in an output register until rsp_o.ready takes it; the
// next request is accepted meanwhile and waits to finish until the
// register is free.
`default_nettype none

module free_list_slot_allocator import fla_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  fla_req_if.sink   req_i,
  fla_rsp_if.source rsp_o
);

  fla_cmd_t cmd;
  fla_sts_t sts;

  fla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fla_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_func_i         (req_i.func),
    .req_slot_index_i   (req_i.slot_index),
    .rsp_ready_i        (rsp_o.ready),
    .rsp_valid_o        (rsp_o.valid),
    .rsp_result_index_o (rsp_o.result_index),
    .rsp_status_o       (rsp_o.status),
    .rsp_live_count_o   (rsp_o.live_count),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import fla_pkg::*;

  // Request code that the block does not define
  localparam logic [FuncW-1:0] FuncSpare = 2'd3;

  localparam int unsigned TableSize   = SlotsDefault;
  localparam int unsigned PhaseWords  = 275;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned ExhaustGoal = 6;

  typedef struct packed {
    logic [SlotIdxW-1:0] idx;
    logic [StatusW-1:0]  st;
    logic [LiveW-1:0]    live;
  } rsp_word_t;

  typedef struct packed {
    logic [FuncW-1:0]    func;
    logic [SlotIdxW-1:0] slot;
    logic                typed;
    rsp_word_t           word;
  } plan_row_t;

  typedef enum logic [1:0] {IdleOff, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  // Directed requests from reset; typed rows carry the result read off by hand
  localparam int unsigned PlanRows = 24;
  localparam plan_row_t DirectedPlan [PlanRows] = '{
    '{FuncFind,  10'd0,    1'b1, '{10'd0, StOk,   11'd2}},
    '{FuncFree,  10'd1023, 1'b1, '{10'd0, StBad,  11'd2}},
    '{FuncSpare, 10'd0,    1'b1, '{10'd0, StBad,  11'd2}},
    '{FuncAlloc, 10'd1023, 1'b1, '{10'd2, StOk,   11'd3}},
    '{FuncAlloc, 10'd0,    1'b0, '0},
    '{FuncFree,  10'd0,    1'b1, '{10'd0, StOk,   11'd3}},
    '{FuncFind,  10'd0,    1'b0, '0},
    '{FuncFree,  10'd1,    1'b0, '0},
    '{FuncFind,  10'd0,    1'b0, '0},
    '{FuncAlloc, 10'd0,    1'b0, '0},
    '{FuncAlloc, 10'd0,    1'b0, '0},
    '{FuncAlloc, 10'd0,    1'b0, '0},
    '{FuncFree,  10'd3,    1'b0, '0},
    '{FuncFree,  10'd3,    1'b1, '{10'd0, StBad,  11'd4}},
    '{FuncFree,  10'd5,    1'b1, '{10'd0, StBad,  11'd4}},
    '{FuncFree,  10'd2,    1'b0, '0},
    '{FuncFree,  10'd4,    1'b0, '0},
    '{FuncFree,  10'd0,    1'b0, '0},
    '{FuncFree,  10'd1,    1'b0, '0},
    '{FuncFind,  10'd1023, 1'b1, '{10'd0, StNone, 11'd0}},
    '{FuncFree,  10'd1,    1'b1, '{10'd0, StBad,  11'd0}},
    '{FuncAlloc, 10'd0,    1'b0, '0},
    '{FuncFind,  10'd1023, 1'b0, '0},
    '{FuncFree,  10'd1023, 1'b1, '{10'd0, StBad,  11'd1}}
  };

  logic clk_i;
  logic rst_ni;

  fla_req_if req_bus ();
  fla_rsp_if rsp_bus ();

  free_list_slot_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Shadow copy of the slot table
  bit                  shadow_used [TableSize];
  logic [SlotIdxW-1:0] shadow_link [TableSize];
  bit                  shadow_tail [TableSize];
  int unsigned         shadow_head;
  bit                  shadow_list_empty;
  int unsigned         shadow_bump;
  int unsigned         shadow_live;

  rsp_word_t   expected_words [$];
  int unsigned mismatch_count;
  int unsigned send_gap_pct;
  int unsigned stall_pct;

  int unsigned n_alloc_ok;
  int unsigned n_exhausted;
  int unsigned n_free_ok;
  int unsigned n_rejected;
  int unsigned n_find_hit;
  int unsigned n_find_none;

  // Free-running clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Work out the result word of one request and advance the shadow table
  task automatic predict_request(input logic [FuncW-1:0] f, input logic [SlotIdxW-1:0] s,
                                 output rsp_word_t w);
    int unsigned pick;
    bit          granted;
    granted = 1'b0;
    pick    = 0;
    w       = '{idx: '0, st: StOk, live: '0};
    case (f)
      FuncAlloc: begin
        if (!shadow_list_empty) begin
          pick = shadow_head;
          if (shadow_tail[pick]) begin
            shadow_list_empty = 1'b1;
            shadow_head       = 0;
          end else begin
            shadow_head = shadow_link[pick];
          end
          granted = 1'b1;
        end else if (shadow_bump >= TableSize) begin
          w.st = StNone;
          n_exhausted++;
        end else begin
          pick = shadow_bump;
          shadow_bump++;
          granted = 1'b1;
        end
        if (granted) begin
          shadow_used[pick] = 1'b1;
          shadow_live++;
          w.idx = pick[SlotIdxW-1:0];
          n_alloc_ok++;
        end
      end
      FuncFree: begin
        if (!shadow_used[s]) begin
          w.st = StBad;
          n_rejected++;
        end else begin
          shadow_tail[s]    = shadow_list_empty;
          shadow_link[s]    = shadow_list_empty ? '0 : shadow_head[SlotIdxW-1:0];
          shadow_head       = s;
          shadow_list_empty = 1'b0;
          shadow_used[s]    = 1'b0;
          if (shadow_live > 0) shadow_live--;
          n_free_ok++;
        end
      end
      FuncFind: begin
        w.st = StNone;
        for (int unsigned i = 0; i < shadow_bump && i < TableSize; i++) begin
          if (shadow_used[i]) begin
            w.st  = StOk;
            w.idx = i[SlotIdxW-1:0];
            break;
          end
        end
        if (w.st == StOk) n_find_hit++;
        else n_find_none++;
      end
      default: begin
        w.st = StBad;
        n_rejected++;
      end
    endcase
    w.live = shadow_live[LiveW-1:0];
  endtask

  // Pick a slot whose used mark matches, starting from a random place
  function automatic logic [SlotIdxW-1:0] pick_slot(input bit want_used);
    int unsigned start;
    int unsigned k;
    start = $urandom_range(TableSize - 1);
    for (int unsigned n = 0; n < TableSize; n++) begin
      k = (start + n) % TableSize;
      if (shadow_used[k] == want_used) return k[SlotIdxW-1:0];
    end
    return start[SlotIdxW-1:0];
  endfunction

  // Fill the table until it runs dry a few times, then churn near full
  task automatic random_request(output logic [FuncW-1:0] f, output logic [SlotIdxW-1:0] s);
    int unsigned roll;
    bit          filling;
    roll    = $urandom_range(99);
    filling = (n_exhausted < ExhaustGoal);
    s       = $urandom_range(TableSize - 1);
    if (roll < (filling ? 99 : 40)) begin
      f = FuncAlloc;
    end else if (roll < (filling ? 99 : 78)) begin
      f = FuncFree;
      s = pick_slot(1'b1);
    end else if (roll < (filling ? 99 : 86)) begin
      f = FuncFree;
      s = pick_slot(1'b0);
    end else if (roll < (filling ? 99 : 90)) begin
      f = FuncSpare;
    end else begin
      f = FuncFind;
    end
  endtask

  // Drive one request word and hold it until the block takes it
  task automatic issue_request(input logic [FuncW-1:0] f, input logic [SlotIdxW-1:0] s,
                               input logic typed, input rsp_word_t typed_word);
    rsp_word_t w;
    while ($urandom_range(99) < send_gap_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.func       <= f;
    req_bus.slot_index <= s;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predict_request(f, s, w);
    expected_words.push_back(typed ? typed_word : w);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every expected word has come back
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_idle(input idle_mode_e mode);
    send_gap_pct = (mode == IdleSender || mode == IdleReceiver) ?
                   ((mode == IdleSender) ? 50 : 0) : ((mode == IdleBoth) ? 8 : 0);
    stall_pct    = (mode == IdleReceiver) ? 50 : ((mode == IdleBoth) ? 8 : 0);
  endtask

  task automatic check_field(input string label, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: stall at random as the current phase asks
  always @(negedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    rsp_word_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got idx %0d status %0d live %0d",
                 $time, rsp_bus.result_index, rsp_bus.status, rsp_bus.live_count);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("result_index", want.idx, rsp_bus.result_index);
        check_field("status", want.st, rsp_bus.status);
        check_field("live_count", want.live, rsp_bus.live_count);
      end
    end
  end

  // Stimulus
  initial begin
    logic [FuncW-1:0]    f;
    logic [SlotIdxW-1:0] s;
    mismatch_count     = 0;
    n_alloc_ok         = 0;
    n_exhausted        = 0;
    n_free_ok          = 0;
    n_rejected         = 0;
    n_find_hit         = 0;
    n_find_none        = 0;
    send_gap_pct       = 0;
    stall_pct          = 0;
    req_bus.valid      = 1'b0;
    req_bus.func       = FuncAlloc;
    req_bus.slot_index = '0;

    // Shadow table as it stands after reset
    foreach (shadow_used[i]) begin
      shadow_used[i] = (i < 2);
      shadow_link[i] = '0;
      shadow_tail[i] = 1'b0;
    end
    shadow_head       = 0;
    shadow_list_empty = 1'b1;
    shadow_bump       = 2;
    shadow_live       = 2;

    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed table with no idling
    set_idle(IdleOff);
    for (int unsigned r = 0; r < PlanRows; r++) begin
      issue_request(DirectedPlan[r].func, DirectedPlan[r].slot,
                    DirectedPlan[r].typed, DirectedPlan[r].word);
    end
    drain_results();

    // Random phases, one per idling pattern
    for (int p = 0; p < 4; p++) begin
      set_idle(idle_mode_e'(p));
      for (int unsigned n = 0; n < PhaseWords; n++) begin
        random_request(f, s);
        issue_request(f, s, 1'b0, '0);
      end
      drain_results();
    end

    set_idle(IdleOff);
    repeat (SettleCycles) @(posedge clk_i);

    $display("run covered %0d allocations, %0d exhausted allocates, %0d frees,",
             n_alloc_ok, n_exhausted, n_free_ok);
    $display("%0d rejected requests and %0d finds (%0d with no slot in use)",
             n_rejected, n_find_hit + n_find_none, n_find_none);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #50_000_000;
    $display("timeout with %0d result words outstanding", expected_words.size());
    $display("testbench: errors");
    $finish;
  end

endmodule

`default_nettype wire
